[rtl/core/md5_pkg.sv]
// Shared types, constants and tables for the MD5 digest block.
package md5_pkg;

  localparam int InW    = 40;
  localparam int OutW   = 40;

  typedef enum logic [2:0] {
    WR_DATA,
    WR_PADDED,
    WR_PAD80,
    WR_ZERO,
    WR_LEN_LO,
    WR_LEN_HI
  } wr_kind_t;

  typedef struct packed {
    logic       wr_en;
    wr_kind_t   wr_kind;
    logic [2:0] nbytes;
    logic       cnt_en;
    logic       round_en;
    logic [5:0] round_idx;
    logic       add_en;
    logic       clear;
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] wp;
  } dp_stat_t;

  function automatic logic [31:0] init_word(input logic [1:0] i);
    logic [31:0] r;
    case (i)
      2'd0: r = 32'h67452301;
      2'd1: r = 32'hefcdab89;
      2'd2: r = 32'h98badcfe;
      default: r = 32'h10325476;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] shift_amt(input logic [5:0] j);
    logic [4:0] r;
    case ({j[5:4], j[1:0]})
      4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
      4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
      4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sine_k(input logic [5:0] j);
    logic [31:0] r;
    case (j)
      6'd0: r = 32'hd76aa478;  6'd1: r = 32'he8c7b756;  6'd2: r = 32'h242070db;
      6'd3: r = 32'hc1bdceee;  6'd4: r = 32'hf57c0faf;  6'd5: r = 32'h4787c62a;
      6'd6: r = 32'ha8304613;  6'd7: r = 32'hfd469501;  6'd8: r = 32'h698098d8;
      6'd9: r = 32'h8b44f7af;  6'd10: r = 32'hffff5bb1; 6'd11: r = 32'h895cd7be;
      6'd12: r = 32'h6b901122; 6'd13: r = 32'hfd987193; 6'd14: r = 32'ha679438e;
      6'd15: r = 32'h49b40821; 6'd16: r = 32'hf61e2562; 6'd17: r = 32'hc040b340;
      6'd18: r = 32'h265e5a51; 6'd19: r = 32'he9b6c7aa; 6'd20: r = 32'hd62f105d;
      6'd21: r = 32'h02441453; 6'd22: r = 32'hd8a1e681; 6'd23: r = 32'he7d3fbc8;
      6'd24: r = 32'h21e1cde6; 6'd25: r = 32'hc33707d6; 6'd26: r = 32'hf4d50d87;
      6'd27: r = 32'h455a14ed; 6'd28: r = 32'ha9e3e905; 6'd29: r = 32'hfcefa3f8;
      6'd30: r = 32'h676f02d9; 6'd31: r = 32'h8d2a4c8a; 6'd32: r = 32'hfffa3942;
      6'd33: r = 32'h8771f681; 6'd34: r = 32'h6d9d6122; 6'd35: r = 32'hfde5380c;
      6'd36: r = 32'ha4beea44; 6'd37: r = 32'h4bdecfa9; 6'd38: r = 32'hf6bb4b60;
      6'd39: r = 32'hbebfbc70; 6'd40: r = 32'h289b7ec6; 6'd41: r = 32'heaa127fa;
      6'd42: r = 32'hd4ef3085; 6'd43: r = 32'h04881d05; 6'd44: r = 32'hd9d4d039;
      6'd45: r = 32'he6db99e5; 6'd46: r = 32'h1fa27cf8; 6'd47: r = 32'hc4ac5665;
      6'd48: r = 32'hf4292244; 6'd49: r = 32'h432aff97; 6'd50: r = 32'hab9423a7;
      6'd51: r = 32'hfc93a039; 6'd52: r = 32'h655b59c3; 6'd53: r = 32'h8f0ccc92;
      6'd54: r = 32'hffeff47d; 6'd55: r = 32'h85845dd1; 6'd56: r = 32'h6fa87e4f;
      6'd57: r = 32'hfe2ce6e0; 6'd58: r = 32'ha3014314; 6'd59: r = 32'h4e0811a1;
      6'd60: r = 32'hf7537e82; 6'd61: r = 32'hbd3af235; 6'd62: r = 32'h2ad7d2bb;
      default: r = 32'heb86d391;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/md5_dpath.sv]
// Datapath: block buffer, byte counter, round words and chaining words.
module md5_dpath (
  input  logic                   clk,
  input  logic                   rst,
  input  md5_pkg::dp_cmd_t       cmd,
  input  logic [31:0]            data_word,
  input  logic [1:0]             out_idx,
  output md5_pkg::dp_stat_t      stat,
  output logic [31:0]            digest_word
);

  logic [31:0] buffer [16];
  logic [3:0]  wp;
  logic [60:0] count;
  logic [31:0] chain [4];
  logic [31:0] rw [4];
  logic [31:0] wr_word;
  logic [31:0] padded;
  logic [31:0] mix;
  logic [3:0]  g;
  logic [5:0]  j;
  logic [31:0] sum;
  logic [63:0] rot;
  logic [31:0] nxt;

  assign j = cmd.round_idx;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < cmd.nbytes) padded[i*8 +: 8] = data_word[i*8 +: 8];
      else if (3'(i) == cmd.nbytes) padded[i*8 +: 8] = 8'h80;
      else padded[i*8 +: 8] = 8'h00;
    end
  end

  always_comb begin
    case (cmd.wr_kind)
      md5_pkg::WR_DATA:   wr_word = data_word;
      md5_pkg::WR_PADDED: wr_word = padded;
      md5_pkg::WR_PAD80:  wr_word = 32'h00000080;
      md5_pkg::WR_LEN_LO: wr_word = {count[28:0], 3'b000};
      md5_pkg::WR_LEN_HI: wr_word = count[60:29];
      default:            wr_word = '0;
    endcase
  end

  always_comb begin
    case (j[5:4])
      2'd0: begin
        mix = (rw[1] & rw[2]) | (~rw[1] & rw[3]);
        g   = j[3:0];
      end
      2'd1: begin
        mix = (rw[1] & rw[3]) | (rw[2] & ~rw[3]);
        g   = 4'({j[3:0], 2'b00} + {2'b00, j[3:0]} + 6'd1);
      end
      2'd2: begin
        mix = rw[1] ^ rw[2] ^ rw[3];
        g   = 4'({j[3:0], 1'b0} + {1'b0, j[3:0]} + 5'd5);
      end
      default: begin
        mix = rw[2] ^ (rw[1] | ~rw[3]);
        g   = 4'({j[3:0], 3'b000} - {3'b000, j[3:0]});
      end
    endcase
    sum = rw[0] + mix + buffer[g] + md5_pkg::sine_k(j);
    rot = {sum, sum} << md5_pkg::shift_amt(j);
    nxt = rw[1] + rot[63:32];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      buffer[wp] <= wr_word;
    end
    if (rst || cmd.clear) begin
      wp    <= '0;
      count <= '0;
      for (int i = 0; i < 4; i++) begin
        chain[i] <= md5_pkg::init_word(2'(i));
        rw[i]    <= md5_pkg::init_word(2'(i));
      end
    end else begin
      if (cmd.wr_en) begin
        wp <= wp + 4'd1;
      end
      if (cmd.cnt_en) begin
        count <= count + {58'd0, cmd.nbytes};
      end
      if (cmd.round_en) begin
        rw[0] <= rw[3];
        rw[3] <= rw[2];
        rw[2] <= rw[1];
        rw[1] <= nxt;
      end
      if (cmd.add_en) begin
        for (int i = 0; i < 4; i++) begin
          chain[i] <= chain[i] + rw[i];
          rw[i]    <= chain[i] + rw[i];
        end
      end
    end
  end

  assign stat.wp      = wp;
  assign digest_word  = chain[out_idx];

endmodule

[rtl/core/md5_ctrl.sv]
// Controller: input intake, padding sequence, round count and digest output.
module md5_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_valid,
  input  logic [2:0]            word_bytes,
  input  logic                  last_word,
  output logic                  s_ready,
  output logic                  m_valid,
  input  logic                  m_ready,
  output logic [1:0]            out_idx,
  output md5_pkg::dp_cmd_t      cmd,
  input  md5_pkg::dp_stat_t     stat
);

  typedef enum logic [2:0] {S_IN, S_PAD, S_COMP, S_ADD, S_OUT} state_t;

  state_t     state;
  logic [5:0] round;
  logic       padding;
  logic       need80;
  logic       allow_len;
  logic       finish;
  logic [2:0] nsat;
  logic       accept;
  md5_pkg::wr_kind_t pad_kind;

  assign nsat   = (word_bytes > 3'd4) ? 3'd4 : word_bytes;
  assign accept = (state == S_IN) && s_valid;
  assign s_ready = (state == S_IN);
  assign m_valid = (state == S_OUT);

  always_comb begin
    if (need80) pad_kind = md5_pkg::WR_PAD80;
    else if (allow_len && stat.wp == 4'd14) pad_kind = md5_pkg::WR_LEN_LO;
    else if (allow_len && stat.wp == 4'd15) pad_kind = md5_pkg::WR_LEN_HI;
    else pad_kind = md5_pkg::WR_ZERO;
  end

  always_comb begin
    cmd = '0;
    cmd.round_idx = round;
    cmd.nbytes    = last_word ? nsat : 3'd4;
    unique case (state)
      S_IN: begin
        cmd.wr_en   = accept;
        cmd.cnt_en  = accept;
        cmd.wr_kind = (last_word && nsat != 3'd4) ? md5_pkg::WR_PADDED : md5_pkg::WR_DATA;
      end
      S_PAD: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_kind = pad_kind;
      end
      S_COMP:  cmd.round_en = 1'b1;
      S_ADD:   cmd.add_en   = 1'b1;
      S_OUT:   cmd.clear    = m_ready && out_idx == 2'd3;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IN;
      round     <= '0;
      padding   <= 1'b0;
      need80    <= 1'b0;
      allow_len <= 1'b0;
      finish    <= 1'b0;
      out_idx   <= '0;
    end else begin
      unique case (state)
        S_IN: begin
          if (accept) begin
            if (last_word) begin
              padding   <= 1'b1;
              need80    <= (nsat == 3'd4);
              allow_len <= (stat.wp <= 4'd13);
            end
            if (stat.wp == 4'd15) state <= S_COMP;
            else if (last_word) state <= S_PAD;
          end
        end
        S_PAD: begin
          if (need80) begin
            need80    <= 1'b0;
            allow_len <= (stat.wp <= 4'd13);
          end
          if (pad_kind == md5_pkg::WR_LEN_HI) finish <= 1'b1;
          if (stat.wp == 4'd15) state <= S_COMP;
        end
        S_COMP: begin
          round <= round + 6'd1;
          if (round == 6'd63) state <= S_ADD;
        end
        S_ADD: begin
          allow_len <= 1'b1;
          if (finish) state <= S_OUT;
          else if (padding) state <= S_PAD;
          else state <= S_IN;
        end
        S_OUT: begin
          if (m_ready) begin
            out_idx <= out_idx + 2'd1;
            if (out_idx == 2'd3) begin
              state     <= S_IN;
              padding   <= 1'b0;
              finish    <= 1'b0;
              allow_len <= 1'b0;
            end
          end
        end
        default: state <= S_IN;
      endcase
    end
  end

endmodule

[rtl/core/md5_message_digest.sv]
// Top level of the streaming MD5 digest block.
// The slave channel takes the message as 32-bit little-endian words, first
// byte in bits 7:0, with s_tlast on the final word and its valid byte count
// in tdata. Every sixteenth word starts a compression of 64 rounds at one
// round per cycle, followed by an add into the chaining words; input is
// held off meanwhile, so the input rate of a long message is set by the
// single shared round unit. After the last item the block writes the
// padding and the bit length into the block buffer at one word per cycle,
// runs one or two final compressions, and then shows the digest on the
// master channel as four items, A first, with m_tlast on the fourth.
// The digest items stay valid and stable while the receiver stalls; no new
// input is taken until the fourth item is accepted, after which the block
// returns to the initial vector. Reset is synchronous and leaves the block
// ready for a new message with no clearing pass.
module md5_message_digest (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [md5_pkg::InW-1:0]   s_tdata,  // data_word[31:0], word_bytes[34:32]
  input  logic                      s_tlast,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [md5_pkg::OutW-1:0]  m_tdata,  // digest_word[31:0], word_index[33:32]
  output logic                      m_tlast
);

  md5_pkg::dp_cmd_t  cmd;
  md5_pkg::dp_stat_t stat;
  logic [1:0]        out_idx;
  logic [31:0]       digest_word;

  md5_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_tvalid),
    .word_bytes (s_tdata[34:32]),
    .last_word  (s_tlast),
    .s_ready    (s_tready),
    .m_valid    (m_tvalid),
    .m_ready    (m_tready),
    .out_idx    (out_idx),
    .cmd        (cmd),
    .stat       (stat)
  );

  md5_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_word   (s_tdata[31:0]),
    .out_idx     (out_idx),
    .stat        (stat),
    .digest_word (digest_word)
  );

  assign m_tdata = {6'd0, out_idx, digest_word};
  assign m_tlast = (out_idx == 2'd3);

endmodule

[tb/testbench.sv]
// Self-checking testbench for the streaming MD5 digest block.
`timescale 1ns / 1ps

module testbench;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [md5_pkg::InW-1:0] s_tdata = '0;  // data_word[31:0], word_bytes[34:32]
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [md5_pkg::OutW-1:0] m_tdata;  // digest_word[31:0], word_index[33:32]
  logic m_tlast;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        digest_last;
  } digest_item_t;

  digest_item_t digest_q[$];
  logic [31:0] chain[4];
  logic [31:0] blk[16];
  logic [60:0] byte_count;
  logic [5:0]  fill_pos;
  int errors = 0;
  int sent_items = 0;
  int messages = 0;
  int digests_seen = 0;
  int idle_cycles = 0;
  bit stall_long = 1'b0;

  md5_message_digest dut (.*);

  always #6 clk = ~clk;

  function automatic logic [31:0] k_const(input int j);
    return 32'(longint'($floor((2.0 ** 32) * (($sin(j + 1.0) < 0) ?
      -$sin(j + 1.0) : $sin(j + 1.0)))));
  endfunction

  function automatic logic [4:0] rot_of(input int j);
    int t[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    return 5'(t[(j / 16) * 4 + j % 4]);
  endfunction

  task automatic compress_block();
    logic [31:0] a, b, c, d, f, n;
    int g;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int j = 0; j < 64; j++) begin
      case (j / 16)
        0: begin f = (b & c) | (~b & d); g = j; end
        1: begin f = (b & d) | (c & ~d); g = (5 * j + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3 * j + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * j) % 16; end
      endcase
      n = a + f + blk[g] + k_const(j);
      n = (n << rot_of(j)) | (n >> (32 - rot_of(j)));
      a = d; d = c; c = b; b = b + n;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endtask

  task automatic take_byte(input logic [7:0] v);
    blk[fill_pos[5:2]][fill_pos[1:0]*8 +: 8] = v;
    fill_pos++;
    if (fill_pos == 0) compress_block();
  endtask

  task automatic digest_reset();
    for (int i = 0; i < 4; i++) chain[i] = md5_pkg::init_word(2'(i));
    byte_count = '0;
    fill_pos = '0;
  endtask

  task automatic predict_digest(input logic [31:0] w, input logic [2:0] nb, input logic lst);
    int n;
    logic [63:0] bits;
    n = !lst ? 4 : (nb > 4 ? 4 : nb);
    for (int j = 0; j < n; j++) take_byte(w[8*j +: 8]);
    byte_count += 61'(n);
    if (lst) begin
      take_byte(8'h80);
      while (fill_pos != 56) take_byte(8'h00);
      bits = {byte_count, 3'b000};
      for (int j = 0; j < 8; j++) take_byte(bits[8*j +: 8]);
      for (int i = 0; i < 4; i++) digest_q.push_back({chain[i], 2'(i), i == 3});
      digest_reset();
      messages++;
    end
  endtask

  function automatic int gap_len();
    return ($urandom_range(9, 0) == 0) ? $urandom_range(40, 5) : $urandom_range(2, 0);
  endfunction

  task automatic send_word(input logic [31:0] w, input logic [2:0] nb, input logic lst,
                           input bit gaps = 1'b1);
    int g;
    g = gaps ? gap_len() : 0;
    @(negedge clk);
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'b0, nb, w};
    s_tlast <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_digest(w, nb, lst);
    sent_items++;
  endtask

  task automatic finish_send();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic send_message(input int words, input logic [2:0] last_nb, input bit gaps);
    for (int i = 0; i < words; i++)
      send_word($urandom(), (i == words - 1) ? last_nb : 3'($urandom_range(7, 0)),
                i == words - 1, gaps);
    finish_send();
  endtask

  task automatic test_directed();
    send_word(32'h0, 3'd0, 1'b1);
    send_word(32'hffffffff, 3'd4, 1'b1);
    send_word(32'h00000000, 3'd1, 1'b1);
    send_word(32'hffffffff, 3'd7, 1'b1);
    send_word(32'ha5a5a5a5, 3'd5, 1'b1);
    send_message(14, 3'd4, 1'b1);
    send_message(14, 3'd1, 1'b1);
    send_message(16, 3'd0, 1'b1);
    finish_send();
  endtask

  task automatic test_random();
    int lens[8] = '{1, 2, 13, 14, 15, 16, 17, 30};
    while (sent_items < 400) begin
      send_message(($urandom_range(3, 0) == 0) ? lens[$urandom_range(7, 0)] :
                   $urandom_range(40, 1), 3'($urandom_range(7, 0)), $urandom_range(3, 0) != 0);
    end
  endtask

  task automatic test_backpressure();
    stall_long = 1'b1;
    send_message(3, 3'd2, 1'b0);
    send_message(20, 3'd3, 1'b0);
    finish_send();
    stall_long = 1'b0;
  endtask

  always @(negedge clk) begin
    int hold;
    if (rst) m_tready <= 1'b0;
    else if (stall_long) begin
      m_tready <= 1'b0;
      repeat (600) @(negedge clk);
      m_tready <= 1'b1;
      @(negedge clk);
    end else begin
      hold = ($urandom_range(3, 0) == 0) ? gap_len() : 0;
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    digest_item_t got, exp_item;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[31:0], m_tdata[33:32], m_tlast};
        digests_seen++;
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest item %h", $time, got);
          errors++;
        end else begin
          exp_item = digest_q.pop_front();
          if (got.digest_word !== exp_item.digest_word) begin
            $display("%0t: digest_word expected %h actual %h", $time,
                     exp_item.digest_word, got.digest_word);
            errors++;
          end
          if (got.word_index !== exp_item.word_index) begin
            $display("%0t: word_index expected %0d actual %0d", $time,
                     exp_item.word_index, got.word_index);
            errors++;
          end
          if (got.digest_last !== exp_item.digest_last) begin
            $display("%0t: digest_last expected %b actual %b", $time,
                     exp_item.digest_last, got.digest_last);
            errors++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 5000) begin
        $display("%0t: no progress, %0d digest items outstanding", $time, digest_q.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    digest_reset();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random();
    while (digest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d message words in %0d messages, checked %0d digest items.",
             sent_items, messages, digests_seen);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

[sim.f]
rtl/core/md5_pkg.sv
rtl/core/md5_dpath.sv
rtl/core/md5_ctrl.sv
rtl/core/md5_message_digest.sv
tb/testbench.sv
